// ----- hdl/sfp_pkg.sv -----
// Shared types and constants for the sync frame parser.
`default_nettype none

package sfp_pkg;

  localparam logic [7:0] SyncFirst  = 8'hAA;
  localparam logic [7:0] SyncSecond = 8'h55;

  // Byte position within a frame: hunt, second sync byte, then frame bytes.
  typedef enum logic [3:0] {
    POS_HUNT   = 4'd0,
    POS_SYNC2  = 4'd1,
    POS_MODULE = 4'd2,
    POS_TYPE   = 4'd3,
    POS_PAY0   = 4'd4,
    POS_PAY1   = 4'd5,
    POS_PAY2   = 4'd6,
    POS_PAY3   = 4'd7,
    POS_CHECK  = 4'd8
  } pos_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SUM    = 2'd1,
    ST_BAD_MODULE = 2'd2
  } frame_status_e;

  typedef struct packed {
    frame_status_e frame_status;
    logic [7:0]    src_module;
    logic [7:0]    frame_type;
    logic [31:0]   payload;
  } frame_result_t;

endpackage

`default_nettype wire

// ----- hdl/sfp_parser.sv -----
// Per-byte frame state machine with running checksum and field capture.
`default_nettype none

module sfp_parser (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  byte_valid_i,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic [7:0]            accepted_module_i,
  output logic                       result_valid_o,
  output sfp_pkg::frame_result_t     result_o
);

  sfp_pkg::pos_e pos_q, pos_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    module_q, module_d;
  logic [7:0]    type_q, type_d;
  logic [31:0]   payload_q, payload_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= sfp_pkg::POS_HUNT;
      sum_q     <= 8'd0;
      module_q  <= 8'd0;
      type_q    <= 8'd0;
      payload_q <= 32'd0;
    end else if (byte_valid_i) begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      module_q  <= module_d;
      type_q    <= type_d;
      payload_q <= payload_d;
    end
  end

  always_comb begin
    pos_d          = sfp_pkg::POS_HUNT;
    sum_d          = sum_q;
    module_d       = module_q;
    type_d         = type_q;
    payload_d      = payload_q;
    result_valid_o = 1'b0;
    result_o.src_module = module_q;
    result_o.frame_type = type_q;
    result_o.payload    = payload_q;
    if (rx_byte_i != sum_q) begin
      result_o.frame_status = sfp_pkg::ST_BAD_SUM;
    end else if (module_q != accepted_module_i) begin
      result_o.frame_status = sfp_pkg::ST_BAD_MODULE;
    end else begin
      result_o.frame_status = sfp_pkg::ST_OK;
    end

    unique case (pos_q)
      sfp_pkg::POS_SYNC2: begin
        if (rx_byte_i == sfp_pkg::SyncSecond) begin
          sum_d = sum_q + rx_byte_i;
          pos_d = sfp_pkg::POS_MODULE;
        end else if (rx_byte_i == sfp_pkg::SyncFirst) begin
          // repeated first sync byte: restart the sum
          sum_d = sfp_pkg::SyncFirst;
          pos_d = sfp_pkg::POS_SYNC2;
        end
      end
      sfp_pkg::POS_MODULE: begin
        module_d = rx_byte_i;
        sum_d    = sum_q + rx_byte_i;
        pos_d    = sfp_pkg::POS_TYPE;
      end
      sfp_pkg::POS_TYPE: begin
        type_d = rx_byte_i;
        sum_d  = sum_q + rx_byte_i;
        pos_d  = sfp_pkg::POS_PAY0;
      end
      sfp_pkg::POS_PAY0, sfp_pkg::POS_PAY1, sfp_pkg::POS_PAY2, sfp_pkg::POS_PAY3: begin
        // little endian: shift earlier bytes down
        payload_d = {rx_byte_i, payload_q[31:8]};
        sum_d     = sum_q + rx_byte_i;
        pos_d     = sfp_pkg::pos_e'(pos_q + 4'd1);
      end
      sfp_pkg::POS_CHECK: begin
        result_valid_o = 1'b1;
        sum_d          = 8'd0;
        pos_d          = sfp_pkg::POS_HUNT;
      end
      default: begin
        // hunt, also for positions that cannot arise
        if (rx_byte_i == sfp_pkg::SyncFirst) begin
          sum_d = sfp_pkg::SyncFirst;
          pos_d = sfp_pkg::POS_SYNC2;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/sync_frame_parser_with_checksum.sv -----
// A status transaction is registered and appears in the cycle after the checksum byte is accepted.
// Throughput: one byte per cycle unless stalled; parser state updates in the cycle of acceptance.
// The output register takes a new status whenever it is empty or being drained.
// Reset (rst_ni low, asynchronous) returns to hunting, clears sum and held fields,
// sets accepted_module to zero and empties the output register.
`default_nettype none

module sync_frame_parser_with_checksum (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accepted_module_we_i,
  input  wire logic [7:0]  accepted_module_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [7:0] src module, [15:8] frame_type, [47:16] payload
  output logic [1:0]       m_axis_tuser    // [1:0] frame_status
);

  logic [7:0]             acc_module_q;
  logic                   in_fire;
  logic                   res_valid;
  sfp_pkg::frame_result_t res;
  logic                   out_valid_q;
  sfp_pkg::frame_result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_module_q <= 8'd0;
    end else if (accepted_module_we_i) begin
      acc_module_q <= accepted_module_i;
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  sfp_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .byte_valid_i      (in_fire),
    .rx_byte_i         (s_axis_tdata),
    .accepted_module_i (acc_module_q),
    .result_valid_o    (res_valid),
    .result_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= in_fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.payload, out_q.frame_type, out_q.src_module};
  assign m_axis_tuser  = out_q.frame_status;

endmodule

`default_nettype wire
